/* rtl/rvu_pkg.sv */
// Shared widths, types and constants of the refraction vector unit.
package rvu_pkg;

  localparam int IN_W            = 16;
  localparam int OUT_W           = 20;
  localparam int D_W             = 33;
  localparam int T42_W           = 49;
  localparam int T28_W           = 35;
  localparam int EP_W            = 52;
  localparam int PAR_W           = 29;
  localparam int SQ_W            = 59;
  localparam int RAD_W           = 42;
  localparam int ROOT_W          = 21;
  localparam int REM_W           = 24;
  localparam int R34_W           = 44;
  localparam int RND_W           = 24;
  localparam int SQRT_STEPS      = 21;
  localparam int STEPS_PER_STAGE = 3;
  localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;

  localparam logic signed [SQ_W-1:0]  ONE_Q40 = SQ_W'(64'sd1 <<< 40);
  localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'(524287);
  localparam logic signed [RND_W-1:0] OUT_MIN = -RND_W'(524288);

  typedef logic signed [IN_W-1:0]  coord_t;
  typedef logic [IN_W-1:0]         ratio_t;
  typedef logic signed [PAR_W-1:0] par_t;
  typedef logic signed [OUT_W-1:0] out_t;
  typedef logic [ROOT_W-1:0]       root_t;

  typedef struct packed {
    par_t   [2:0] par;
    coord_t [2:0] nrm;
    logic         tir;
  } carry_t;

endpackage

/* rtl/rvu_front.sv */
// Dot product, tangential correction and index scaling: three register stages.
module rvu_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rvu_pkg::coord_t [2:0] inc,
  input  rvu_pkg::coord_t [2:0] nrm,
  input  rvu_pkg::ratio_t       eta,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rvu_pkg::par_t   [2:0] par,
  output rvu_pkg::coord_t [2:0] par_nrm
);

  logic v1, v2, v3;
  logic su2, su3;
  logic ld1, ld2, ld3;

  rvu_pkg::coord_t [2:0] inc1, nrm1, nrm2;
  rvu_pkg::ratio_t       eta1, eta2;
  logic signed [rvu_pkg::D_W-1:0]   d1;
  logic signed [rvu_pkg::T28_W-1:0] t28 [3];

  logic signed [2*rvu_pkg::IN_W-1:0]     prod1 [3];
  logic signed [rvu_pkg::D_W:0]          dot;
  logic signed [rvu_pkg::D_W:0]          dot_neg;
  logic signed [rvu_pkg::T42_W-1:0]      prod2 [3];
  logic signed [rvu_pkg::T42_W:0]        t42 [3];
  logic signed [rvu_pkg::T42_W:0]        t42_rnd [3];
  logic signed [rvu_pkg::EP_W-1:0]       ep [3];
  logic signed [rvu_pkg::EP_W-1:0]       ep_rnd [3];

  assign su3       = v3 && out_stall;
  assign su2       = v2 && su3;
  assign in_stall  = v1 && su2;
  assign ld3       = !su3;
  assign ld2       = !su2;
  assign ld1       = !in_stall;
  assign out_valid = v3;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod1[k] = $signed(inc[k]) * $signed(nrm[k]);
    end
    dot     = prod1[0] + prod1[1] + prod1[2];
    dot_neg = -dot;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod2[k]   = $signed(nrm1[k]) * d1;
      t42[k]     = ($signed((rvu_pkg::T42_W+1)'($signed(inc1[k]))) <<< 28) + prod2[k];
      t42_rnd[k] = (t42[k] + (rvu_pkg::T42_W+1)'(1 << 13)) >>> 14;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ep[k]     = $signed({1'b0, eta2}) * t28[k];
      ep_rnd[k] = (ep[k] + rvu_pkg::EP_W'(1 << 21)) >>> 22;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      inc1 <= inc;
      nrm1 <= nrm;
      eta1 <= eta;
      d1   <= dot_neg[rvu_pkg::D_W-1:0];
    end
    if (ld2) begin
      nrm2 <= nrm1;
      eta2 <= eta1;
      for (int k = 0; k < 3; k++) begin
        t28[k] <= t42_rnd[k][rvu_pkg::T28_W-1:0];
      end
    end
    if (ld3) begin
      par_nrm <= nrm2;
      for (int k = 0; k < 3; k++) begin
        par[k] <= ep_rnd[k][rvu_pkg::PAR_W-1:0];
      end
    end
  end

endmodule

/* rtl/rvu_root.sv */
// Squared length, reflection test and pipelined digit-by-digit square root.
module rvu_root (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rvu_pkg::par_t   [2:0] par,
  input  rvu_pkg::coord_t [2:0] nrm,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rvu_pkg::root_t        root,
  output rvu_pkg::carry_t       carry
);

  localparam int NS = rvu_pkg::SQRT_STAGES;

  logic                       sv   [NS+1];
  logic                       su   [NS+1];
  logic [rvu_pkg::RAD_W-1:0]  rad  [NS+1];
  logic [rvu_pkg::REM_W-1:0]  rem  [NS+1];
  rvu_pkg::root_t             rt   [NS+1];
  rvu_pkg::carry_t            cy   [NS+1];

  logic signed [2*rvu_pkg::PAR_W-1:0] sq [3];
  logic signed [rvu_pkg::SQ_W-1:0]    q;
  logic signed [rvu_pkg::SQ_W-1:0]    a;
  logic                               tir;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq[k] = $signed(par[k]) * $signed(par[k]);
    end
    q   = sq[0] + sq[1] + sq[2];
    tir = q > rvu_pkg::ONE_Q40;
    a   = rvu_pkg::ONE_Q40 - q;
  end

  assign in_stall  = su[0];
  assign out_valid = sv[NS];
  assign root      = rt[NS];
  assign carry     = cy[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (!su[0]) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!su[0]) begin
      rad[0]       <= tir ? '0 : {1'b0, a[rvu_pkg::RAD_W-2:0]};
      rem[0]       <= '0;
      rt[0]        <= '0;
      cy[0].par    <= par;
      cy[0].nrm    <= nrm;
      cy[0].tir    <= tir;
    end
  end

  assign su[0] = sv[0] && su[1];
  assign su[NS] = sv[NS] && out_stall;

  for (genvar g = 1; g <= NS; g++) begin : g_sqrt
    logic [rvu_pkg::REM_W-1:0] rem_w;
    logic [rvu_pkg::REM_W-1:0] trial;
    rvu_pkg::root_t            rt_w;

    if (g < NS) begin : g_mid
      assign su[g] = sv[g] && su[g+1];
    end

    always_comb begin
      rem_w = rem[g-1];
      rt_w  = rt[g-1];
      for (int j = 0; j < rvu_pkg::STEPS_PER_STAGE; j++) begin
        rem_w = {rem_w[rvu_pkg::REM_W-3:0],
                 rad[g-1][2*(rvu_pkg::SQRT_STEPS-1-((g-1)*rvu_pkg::STEPS_PER_STAGE+j)) +: 2]};
        trial = {1'b0, rt_w, 2'b01};
        if (rem_w >= trial) begin
          rem_w = rem_w - trial;
          rt_w  = {rt_w[rvu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rt_w  = {rt_w[rvu_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g] <= 1'b0;
      end else if (!su[g]) begin
        sv[g] <= sv[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!su[g]) begin
        rad[g] <= rad[g-1];
        rem[g] <= rem_w;
        rt[g]  <= rt_w;
        cy[g]  <= cy[g-1];
      end
    end
  end

endmodule

/* rtl/rvu_out.sv */
// Perpendicular term, rounding, saturation and output register.
module rvu_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rvu_pkg::root_t      root,
  input  rvu_pkg::carry_t     carry,
  output logic                out_valid,
  input  logic                out_stall,
  output rvu_pkg::out_t [2:0] res,
  output logic                tir,
  output logic                sat
);

  logic signed [rvu_pkg::IN_W+rvu_pkg::ROOT_W:0] np [3];
  logic signed [rvu_pkg::R34_W-1:0]              r34 [3];
  logic signed [rvu_pkg::R34_W-1:0]              r34_rnd [3];
  logic signed [rvu_pkg::RND_W-1:0]              r [3];
  rvu_pkg::out_t [2:0]                           res_next;
  logic                                          sat_next;

  assign in_stall = out_valid && out_stall;

  always_comb begin
    sat_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      np[k]      = $signed(carry.nrm[k]) * $signed({1'b0, root});
      r34[k]     = ($signed(rvu_pkg::R34_W'($signed(carry.par[k]))) <<< 14) - np[k];
      r34_rnd[k] = (r34[k] + rvu_pkg::R34_W'(1 << 19)) >>> 20;
      r[k]       = r34_rnd[k][rvu_pkg::RND_W-1:0];
      if (r[k] > rvu_pkg::OUT_MAX) begin
        res_next[k] = rvu_pkg::OUT_MAX[rvu_pkg::OUT_W-1:0];
        sat_next    = 1'b1;
      end else if (r[k] < rvu_pkg::OUT_MIN) begin
        res_next[k] = rvu_pkg::OUT_MIN[rvu_pkg::OUT_W-1:0];
        sat_next    = 1'b1;
      end else begin
        res_next[k] = r[k][rvu_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      res <= res_next;
      tir <= carry.tir;
      sat <= sat_next;
    end
  end

endmodule

/* rtl/refraction_vector_unit.sv */
// Top level of the refraction vector unit.
//
// Input channel: in_valid / in_stall with the incident direction, the unit
// surface normal (signed Q2.14) and the index ratio (unsigned Q2.14). A request
// is taken at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with the refracted direction
// (signed Q6.14, clipped to range), the internal reflection flag and the
// saturation flag. One result leaves for every request taken, in order.
// The stages are: three for dot product, tangential term and index scaling,
// one for the squared length, seven for the square root at three result bits
// per stage, and the output register.
// Throughput is one request per cycle unless stalled; the seven-stage root
// pipeline and the per-stage multipliers each take a new request every cycle.
// Reset clears every stage valid bit; nothing in flight survives it.
// When the receiver stalls, the output register holds its result and the
// stall moves back stage by stage only through occupied stages, so empty
// stages keep filling and in_stall rises only once the pipeline is full.
module refraction_vector_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   incident_x,
  input  logic signed [15:0]   incident_y,
  input  logic signed [15:0]   incident_z,
  input  logic signed [15:0]   normal_x,
  input  logic signed [15:0]   normal_y,
  input  logic signed [15:0]   normal_z,
  input  logic [15:0]          index_ratio,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [19:0]   refracted_x,
  output logic signed [19:0]   refracted_y,
  output logic signed [19:0]   refracted_z,
  output logic                 internal_reflection,
  output logic                 saturated
);

  rvu_pkg::coord_t [2:0] inc;
  rvu_pkg::coord_t [2:0] nrm;
  rvu_pkg::par_t   [2:0] par;
  rvu_pkg::coord_t [2:0] par_nrm;
  rvu_pkg::root_t        root;
  rvu_pkg::carry_t       carry;
  rvu_pkg::out_t   [2:0] res;
  logic                  front_valid, front_stall;
  logic                  root_valid, root_stall;

  assign inc[0] = incident_x;
  assign inc[1] = incident_y;
  assign inc[2] = incident_z;
  assign nrm[0] = normal_x;
  assign nrm[1] = normal_y;
  assign nrm[2] = normal_z;

  rvu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .inc       (inc),
    .nrm       (nrm),
    .eta       (index_ratio),
    .out_valid (front_valid),
    .out_stall (front_stall),
    .par       (par),
    .par_nrm   (par_nrm)
  );

  rvu_root u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .par       (par),
    .nrm       (par_nrm),
    .out_valid (root_valid),
    .out_stall (root_stall),
    .root      (root),
    .carry     (carry)
  );

  rvu_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (root_valid),
    .in_stall  (root_stall),
    .root      (root),
    .carry     (carry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .tir       (internal_reflection),
    .sat       (saturated)
  );

  assign refracted_x = res[0];
  assign refracted_y = res[1];
  assign refracted_z = res[2];

endmodule

/* sim/refraction_vector_unit_tb.sv */
// Self-checking testbench for the refraction vector unit: scoreboard class and top module.
`timescale 1ns / 100ps

typedef struct packed {
  rvu_pkg::coord_t ix;
  rvu_pkg::coord_t iy;
  rvu_pkg::coord_t iz;
  rvu_pkg::coord_t nx;
  rvu_pkg::coord_t ny;
  rvu_pkg::coord_t nz;
  rvu_pkg::ratio_t eta;
} ray_req_t;

typedef struct packed {
  rvu_pkg::out_t x;
  rvu_pkg::out_t y;
  rvu_pkg::out_t z;
  logic          tir;
  logic          sat;
} ray_res_t;

class refraction_scoreboard;
  ray_res_t expected_dirs[$];
  int       mismatch_count = 0;

  function longint round_down_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function longint floor_root(longint v);
    longint acc;
    longint trial;
    int     b;
    acc = 0;
    for (b = 20; b >= 0; b--) begin
      trial = acc | (64'sd1 <<< b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function ray_res_t predict_refraction(ray_req_t r);
    longint        inc[3];
    longint        nrm[3];
    longint        par[3];
    longint        eta;
    longint        dot;
    longint        t28;
    longint        len2;
    longint        rad;
    longint        root;
    longint        comp;
    rvu_pkg::out_t dir[3];
    ray_res_t      res;
    int            k;
    inc[0] = r.ix;
    inc[1] = r.iy;
    inc[2] = r.iz;
    nrm[0] = r.nx;
    nrm[1] = r.ny;
    nrm[2] = r.nz;
    eta    = r.eta;
    dot    = 0;
    len2   = 0;
    res    = '0;
    for (k = 0; k < 3; k++) dot -= nrm[k] * inc[k];
    for (k = 0; k < 3; k++) begin
      t28    = round_down_shift((inc[k] <<< 28) + nrm[k] * dot, 14);
      par[k] = round_down_shift(eta * t28, 22);
      len2  += par[k] * par[k];
    end
    rad = (64'sd1 <<< 40) - len2;
    if (rad < 0) begin
      res.tir = 1'b1;
      root    = 0;
    end else begin
      root = floor_root(rad);
    end
    for (k = 0; k < 3; k++) begin
      comp = round_down_shift(par[k] * 16384 - nrm[k] * root, 20);
      if (comp > 524287) begin
        comp    = 524287;
        res.sat = 1'b1;
      end else if (comp < -524288) begin
        comp    = -524288;
        res.sat = 1'b1;
      end
      dir[k] = rvu_pkg::out_t'(comp);
    end
    res.x = dir[0];
    res.y = dir[1];
    res.z = dir[2];
    return res;
  endfunction

  function void note_request(ray_req_t r);
    expected_dirs.push_back(predict_refraction(r));
  endfunction

  function void report_mismatch(string what, ray_res_t exp_res, ray_res_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): exp x=%0d y=%0d z=%0d tir=%0b sat=%0b",
               what, exp_res.x, exp_res.y, exp_res.z, exp_res.tir, exp_res.sat,
               "  got x=%0d y=%0d z=%0d tir=%0b sat=%0b",
               got.x, got.y, got.z, got.tir, got.sat);
  endfunction

  function void check_result(ray_res_t got);
    ray_res_t exp_res;
    if (expected_dirs.size() == 0) begin
      report_mismatch("no request pending", '0, got);
    end else begin
      exp_res = expected_dirs.pop_front();
      if (got.x !== exp_res.x || got.y !== exp_res.y || got.z !== exp_res.z ||
          got.tir !== exp_res.tir || got.sat !== exp_res.sat)
        report_mismatch("wrong field", exp_res, got);
    end
  endfunction

  function int pending();
    return expected_dirs.size();
  endfunction
endclass

module refraction_vector_unit_tb;
  localparam int              CYCLE_LIMIT = 200000;
  localparam int              HOLD_CYCLES = 80;
  localparam int              RANDOM_RAYS = 1600;
  localparam rvu_pkg::coord_t Q_ONE       = 16'sd16384;
  localparam rvu_pkg::coord_t Q_DIAG      = 16'sd11585;
  localparam rvu_pkg::coord_t Q_MAX       = 16'sd32767;
  localparam rvu_pkg::coord_t Q_MIN       = -16'sd32768;
  localparam rvu_pkg::ratio_t ETA_ONE     = 16'd16384;
  localparam rvu_pkg::ratio_t ETA_MAX     = 16'hFFFF;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  rvu_pkg::coord_t incident_x;
  rvu_pkg::coord_t incident_y;
  rvu_pkg::coord_t incident_z;
  rvu_pkg::coord_t normal_x;
  rvu_pkg::coord_t normal_y;
  rvu_pkg::coord_t normal_z;
  rvu_pkg::ratio_t index_ratio;
  logic            out_valid;
  logic            out_stall;
  rvu_pkg::out_t   refracted_x;
  rvu_pkg::out_t   refracted_y;
  rvu_pkg::out_t   refracted_z;
  logic            internal_reflection;
  logic            saturated;

  int     tx_idle_pct = 37;
  int     rx_idle_pct = 37;
  bit     hold_req    = 1'b0;
  int     cycle_count = 0;

  refraction_scoreboard sb;

  refraction_vector_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .incident_x          (incident_x),
    .incident_y          (incident_y),
    .incident_z          (incident_z),
    .normal_x            (normal_x),
    .normal_y            (normal_y),
    .normal_z            (normal_z),
    .index_ratio         (index_ratio),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .refracted_x         (refracted_x),
    .refracted_y         (refracted_y),
    .refracted_z         (refracted_z),
    .internal_reflection (internal_reflection),
    .saturated           (saturated)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial sb = new;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_request('{incident_x, incident_y, incident_z,
                        normal_x, normal_y, normal_z, index_ratio});
    if (!rst && out_valid && !out_stall)
      sb.check_result('{refracted_x, refracted_y, refracted_z,
                        internal_reflection, saturated});
  end

  initial begin
    bit hold_taken;
    int n;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task automatic send_ray(input ray_req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    incident_x  <= r.ix;
    incident_y  <= r.iy;
    incident_z  <= r.iz;
    normal_x    <= r.nx;
    normal_y    <= r.ny;
    normal_z    <= r.nz;
    index_ratio <= r.eta;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic make_unit(output rvu_pkg::coord_t cx, output rvu_pkg::coord_t cy,
                           output rvu_pkg::coord_t cz);
    real vx;
    real vy;
    real vz;
    real len;
    len = 0.0;
    while (len < 0.05) begin
      vx  = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
      vy  = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
      vz  = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
      len = $sqrt(vx * vx + vy * vy + vz * vz);
    end
    cx = rvu_pkg::coord_t'($rtoi(vx / len * 16384.0));
    cy = rvu_pkg::coord_t'($rtoi(vy / len * 16384.0));
    cz = rvu_pkg::coord_t'($rtoi(vz / len * 16384.0));
  endtask

  task automatic make_ray(output ray_req_t r);
    int facing;
    if ($urandom_range(0, 99) < 25) begin
      r = {$urandom, $urandom, $urandom, 16'($urandom)};
    end else begin
      make_unit(r.ix, r.iy, r.iz);
      make_unit(r.nx, r.ny, r.nz);
      facing = r.ix * r.nx + r.iy * r.ny + r.iz * r.nz;
      if (facing > 0 && $urandom_range(0, 9) != 0) begin
        r.nx = -r.nx;
        r.ny = -r.ny;
        r.nz = -r.nz;
      end
      if ($urandom_range(0, 99) < 75) r.eta = rvu_pkg::ratio_t'($urandom_range(8192, 32768));
      else r.eta = rvu_pkg::ratio_t'($urandom);
    end
  endtask

  initial begin
    ray_req_t r;
    int       i;
    rst         = 1'b1;
    in_valid    = 1'b0;
    incident_x  = '0;
    incident_y  = '0;
    incident_z  = '0;
    normal_x    = '0;
    normal_y    = '0;
    normal_z    = '0;
    index_ratio = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_ray('{16'sd0, 16'sd0, -Q_ONE, 16'sd0, 16'sd0, Q_ONE, ETA_ONE});
    send_ray('{16'sd0, 16'sd0, -Q_ONE, 16'sd0, 16'sd0, Q_ONE, 16'd0});
    send_ray('{Q_DIAG, 16'sd0, -Q_DIAG, 16'sd0, 16'sd0, Q_ONE, ETA_MAX});
    send_ray('{Q_DIAG, 16'sd0, -Q_DIAG, 16'sd0, 16'sd0, Q_ONE, 16'd10923});
    send_ray('{Q_DIAG, 16'sd0, -Q_DIAG, 16'sd0, 16'sd0, Q_ONE, 16'd24576});
    send_ray('{Q_ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, Q_ONE, ETA_ONE});
    send_ray('{16'sd0, -Q_ONE, 16'sd0, 16'sd0, Q_ONE, 16'sd0, 16'd32767});
    send_ray('{16'sd0, 16'sd0, Q_MIN, 16'sd0, 16'sd0, Q_MAX, ETA_ONE});
    send_ray('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
    send_ray('{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, ETA_MAX});
    send_ray('{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, ETA_MAX});
    send_ray('{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 16'd1});
    send_ray('{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, ETA_MAX});
    send_ray('{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, ETA_ONE});
    send_ray('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'h5555});
    send_ray('{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'hAAAA});

    for (i = 0; i < RANDOM_RAYS; i++) begin
      if (i == 500) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (i == 600) hold_req = 1'b1;
      if (i == 900) begin
        tx_idle_pct = 37;
        rx_idle_pct = 37;
      end
      make_ray(r);
      send_ray(r);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/rvu_pkg.sv
rtl/rvu_front.sv
rtl/rvu_root.sv
rtl/rvu_out.sv
rtl/refraction_vector_unit.sv
sim/refraction_vector_unit_tb.sv
